/* hw/rtl/qvr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the quaternion vector rotation block.
package qvr_pkg;

    localparam int VEC_W  = 32;   // vector component width, Q15.16
    localparam int QC_W   = 16;   // quaternion component width, Q1.14
    localparam int SQ_W   = 31;   // square of one quaternion component
    localparam int A_W    = 34;   // w^2 - |u|^2, signed
    localparam int N_W    = 33;   // squared norm, unsigned
    localparam int UV_W   = 48;   // one u_i * v_j product
    localparam int DS_W   = 50;   // u . v
    localparam int D2_W   = 51;   // 2 (u . v)
    localparam int C_W    = 49;   // one cross product component
    localparam int W2_W   = 17;   // 2 w
    localparam int PA_W   = 66;   // a * v_i
    localparam int PB_W   = 67;   // d2 * u_i
    localparam int PC_W   = 66;   // w2 * c_i
    localparam int NUM_W  = 70;   // signed numerator
    localparam int MAG_W  = 70;   // numerator magnitude
    localparam int REM_W  = 71;   // divider partial remainder, holds 2 * magnitude
    localparam int QB     = 35;   // bits of floor(2 * magnitude / n)
    localparam int FRONT  = 5;    // stages ahead of the divider
    localparam int LAT    = FRONT + QB + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_W = 2'd3;

    localparam logic signed [QC_W-1:0] QUAT_W_RESET = 16'sd16384;

    typedef struct packed {
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_z;
    } t_vec;

    typedef struct packed {
        logic signed [VEC_W-1:0] rot_x;
        logic signed [VEC_W-1:0] rot_y;
        logic signed [VEC_W-1:0] rot_z;
        logic                    zero_quat_error;
        logic                    saturated;
    } t_rot;

endpackage

/* hw/rtl/qvr_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload item per transaction.
interface qvr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/qvr_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit of floor(2 * mag / n) per stage.
module qvr_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [qvr_pkg::MAG_W-1:0]   i_mag,
    input  logic                        i_neg,
    input  logic [qvr_pkg::N_W-1:0]     i_n,
    output logic [qvr_pkg::QB-1:0]      o_q2,
    output logic                        o_neg,
    output logic                        o_ovf
);
    localparam int REM_W = qvr_pkg::REM_W;
    localparam int QB    = qvr_pkg::QB;

    logic [REM_W-1:0] r_rem [1:QB-1];
    logic [QB-1:0]    r_q   [1:QB];
    logic             r_neg [1:QB];
    logic             r_ovf [1:QB];

    // A magnitude at or above n * 2^34 rounds far beyond 32 bits.
    logic w_ovf0;
    assign w_ovf0 = REM_W'(i_mag) >= (REM_W'(i_n) << (QB - 1));

    genvar s;
    generate
        for (s = 0; s < QB; s++) begin : g_stage
            localparam int K = QB - 1 - s;
            logic [REM_W-1:0] w_prev;
            logic [QB-1:0]    w_qprev;
            logic             w_negprev;
            logic             w_ovfprev;
            logic [REM_W-1:0] w_div;
            logic [REM_W:0]   w_diff;
            logic             w_bit;

            if (s == 0) begin : g_first
                assign w_prev    = {i_mag, 1'b0};
                assign w_qprev   = '0;
                assign w_negprev = i_neg;
                assign w_ovfprev = w_ovf0;
            end else begin : g_next
                assign w_prev    = r_rem[s];
                assign w_qprev   = r_q[s];
                assign w_negprev = r_neg[s];
                assign w_ovfprev = r_ovf[s];
            end

            assign w_div  = REM_W'(i_n) << K;
            assign w_diff = {1'b0, w_prev} - {1'b0, w_div};
            assign w_bit  = ~w_diff[REM_W];

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[s+1]   <= {w_qprev[QB-2:0], w_bit};
                    r_neg[s+1] <= w_negprev;
                    r_ovf[s+1] <= w_ovfprev;
                end
            end

            if (s < QB - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[s+1] <= w_bit ? w_diff[REM_W-1:0] : w_prev;
                    end
                end
            end
        end
    endgenerate

    assign o_q2  = r_q[QB];
    assign o_neg = r_neg[QB];
    assign o_ovf = r_ovf[QB];
endmodule

/* hw/rtl/quaternion_vector_rotate_top.sv */
`timescale 1ns / 1ps
// Top level of the quaternion vector rotation pipeline.
//
// Rotates each vector on i_vec by the quaternion held in four registers and
// delivers one result per vector on o_rot. The quaternion is written through
// i_cfg_we / i_cfg_idx / i_cfg_data (x, y, z, w at indexes 0 to 3). The user
// must see that it is written only while no transaction is in flight; the
// block does not enforce this. Any nonzero quaternion works, its length
// cancels. The numerators are formed exactly, then divided by the squared
// norm with a bit-per-stage restoring divider, rounded half away from zero
// and clamped. Each accepted transaction passes 41 register stages (five of
// multiply and add, 35 divider stages with one quotient bit each, and an
// output register). A new vector is accepted every cycle unless o_rot stalls.
// When the receiver holds o_rot.ready low with a result waiting, the whole
// pipeline freezes and i_vec.ready drops; nothing is lost or repeated.
// Reset clears all valid bits, holds i_vec.ready low and sets the quaternion
// to identity (w = 1.0, x = y = z = 0); the first vector can be accepted
// right after. A zero quaternion yields zero outputs with zero_quat_error set.
module quaternion_vector_rotate_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [qvr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [qvr_pkg::QC_W-1:0]           i_cfg_data,
    qvr_stream_if.sink                         i_vec,
    qvr_stream_if.source                       o_rot
);
    localparam int VEC_W = qvr_pkg::VEC_W;
    localparam int QC_W  = qvr_pkg::QC_W;
    localparam int QB    = qvr_pkg::QB;
    localparam int LAT   = qvr_pkg::LAT;

    typedef struct packed {
        logic [VEC_W-1:0] val;
        logic             sat;
    } t_comp;

    function automatic t_comp finish(input logic [QB-1:0] q2, input logic neg,
                                     input logic ovf);
        logic [QB:0]   sum;
        logic [QB-1:0] rnd;
        logic [QB-1:0] limit;
        logic [QB-1:0] mag;
        t_comp         res;
        sum   = {1'b0, q2} + (QB+1)'(1);
        rnd   = sum[QB:1];
        limit = neg ? (QB'(1) << (VEC_W - 1)) : ((QB'(1) << (VEC_W - 1)) - QB'(1));
        res.sat = ovf || (rnd > limit);
        mag   = res.sat ? limit : rnd;
        res.val = neg ? (VEC_W'(0) - mag[VEC_W-1:0]) : mag[VEC_W-1:0];
        return res;
    endfunction

    // Quaternion registers and the values derived from them.
    logic signed [QC_W-1:0]           r_quat [0:3];
    logic [qvr_pkg::SQ_W-1:0]         r_sq   [0:3];
    logic signed [qvr_pkg::A_W-1:0]   r_a;
    logic [qvr_pkg::N_W-1:0]          r_n;
    logic signed [qvr_pkg::W2_W-1:0]  r_w2;
    logic                             r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat[0] <= '0;
            r_quat[1] <= '0;
            r_quat[2] <= '0;
            r_quat[3] <= qvr_pkg::QUAT_W_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qvr_pkg::CFG_QUAT_X: r_quat[0] <= i_cfg_data;
                qvr_pkg::CFG_QUAT_Y: r_quat[1] <= i_cfg_data;
                qvr_pkg::CFG_QUAT_Z: r_quat[2] <= i_cfg_data;
                qvr_pkg::CFG_QUAT_W: r_quat[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_sq[i] <= qvr_pkg::SQ_W'($unsigned(32'(r_quat[i]) * 32'(r_quat[i])));
        end
        r_a    <= qvr_pkg::A_W'(r_sq[3]) - qvr_pkg::A_W'(r_sq[0])
                - qvr_pkg::A_W'(r_sq[1]) - qvr_pkg::A_W'(r_sq[2]);
        r_n    <= qvr_pkg::N_W'(r_sq[0]) + qvr_pkg::N_W'(r_sq[1])
                + qvr_pkg::N_W'(r_sq[2]) + qvr_pkg::N_W'(r_sq[3]);
        r_w2   <= $signed({r_quat[3], 1'b0});
        r_zero <= (r_quat[0] == '0) && (r_quat[1] == '0)
                && (r_quat[2] == '0) && (r_quat[3] == '0);
    end

    // The pipeline advances as a whole unless a result waits at the output.
    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign w_en        = !r_vld[LAT-1] || o_rot.ready;
    assign i_vec.ready = w_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_vec.valid};
        end
    end

    logic signed [VEC_W-1:0] w_vin [0:2];
    assign w_vin[0] = i_vec.data.vec_x;
    assign w_vin[1] = i_vec.data.vec_y;
    assign w_vin[2] = i_vec.data.vec_z;

    // Stage 1: all nine u_i * v_j products.
    logic signed [qvr_pkg::UV_W-1:0] r_uv  [0:2][0:2];
    logic signed [VEC_W-1:0]         r1_v  [0:2];
    // Stage 2: 2 (u . v) and u x v.
    logic signed [qvr_pkg::D2_W-1:0] r_d2;
    logic signed [qvr_pkg::C_W-1:0]  r_c   [0:2];
    logic signed [VEC_W-1:0]         r2_v  [0:2];
    // Stage 3: the three terms of each numerator.
    logic signed [qvr_pkg::PA_W-1:0] r_pa  [0:2];
    logic signed [qvr_pkg::PB_W-1:0] r_pb  [0:2];
    logic signed [qvr_pkg::PC_W-1:0] r_pc  [0:2];
    // Stage 4: numerators. Stage 5: sign and magnitude.
    logic signed [qvr_pkg::NUM_W-1:0] r_num [0:2];
    logic [qvr_pkg::MAG_W-1:0]        r_mag [0:2];
    logic                             r_neg [0:2];

    logic signed [qvr_pkg::DS_W-1:0] w_dsum;
    assign w_dsum = qvr_pkg::DS_W'(r_uv[0][0]) + qvr_pkg::DS_W'(r_uv[1][1])
                  + qvr_pkg::DS_W'(r_uv[2][2]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_uv[i][j] <= r_quat[i] * w_vin[j];
                end
                r1_v[i] <= w_vin[i];
            end

            r_d2   <= $signed({w_dsum, 1'b0});
            r_c[0] <= qvr_pkg::C_W'(r_uv[1][2]) - qvr_pkg::C_W'(r_uv[2][1]);
            r_c[1] <= qvr_pkg::C_W'(r_uv[2][0]) - qvr_pkg::C_W'(r_uv[0][2]);
            r_c[2] <= qvr_pkg::C_W'(r_uv[0][1]) - qvr_pkg::C_W'(r_uv[1][0]);
            for (int i = 0; i < 3; i++) begin
                r2_v[i] <= r1_v[i];
            end

            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= r_a * r2_v[i];
                r_pb[i] <= r_d2 * r_quat[i];
                r_pc[i] <= r_w2 * r_c[i];
            end

            for (int i = 0; i < 3; i++) begin
                r_num[i] <= qvr_pkg::NUM_W'(r_pa[i]) + qvr_pkg::NUM_W'(r_pb[i])
                          + qvr_pkg::NUM_W'(r_pc[i]);
            end

            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_num[i][qvr_pkg::NUM_W-1];
                r_mag[i] <= r_num[i][qvr_pkg::NUM_W-1] ? qvr_pkg::MAG_W'(-r_num[i])
                                                        : qvr_pkg::MAG_W'(r_num[i]);
            end
        end
    end

    logic [QB-1:0] w_q2  [0:2];
    logic          w_dneg [0:2];
    logic          w_ovf [0:2];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_div
            qvr_div u_div (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_mag (r_mag[g]),
                .i_neg (r_neg[g]),
                .i_n   (r_n),
                .o_q2  (w_q2[g]),
                .o_neg (w_dneg[g]),
                .o_ovf (w_ovf[g])
            );
        end
    endgenerate

    t_comp w_res [0:2];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_res[i] = finish(w_q2[i], w_dneg[i], w_ovf[i]);
        end
    end

    qvr_pkg::t_rot r_out;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_zero) begin
                r_out.rot_x           <= '0;
                r_out.rot_y           <= '0;
                r_out.rot_z           <= '0;
                r_out.zero_quat_error <= 1'b1;
                r_out.saturated       <= 1'b0;
            end else begin
                r_out.rot_x           <= w_res[0].val;
                r_out.rot_y           <= w_res[1].val;
                r_out.rot_z           <= w_res[2].val;
                r_out.zero_quat_error <= 1'b0;
                r_out.saturated       <= w_res[0].sat | w_res[1].sat | w_res[2].sat;
            end
        end
    end

    assign o_rot.valid = r_vld[LAT-1];
    assign o_rot.data  = r_out;
endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the quaternion vector rotation top level.
module tb;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VMIN = 32'sh8000_0000;

    typedef struct {
        bit                              is_cfg;
        logic signed [qvr_pkg::QC_W-1:0] qx, qy, qz, qw;
        qvr_pkg::t_vec                   vec;
        bit                              typed;
        qvr_pkg::t_rot                   rot;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [qvr_pkg::CFG_IDX_W-1:0] i_cfg_idx = qvr_pkg::CFG_QUAT_X;
    logic [qvr_pkg::QC_W-1:0] i_cfg_data = '0;

    qvr_stream_if #(.T(qvr_pkg::t_vec)) vec_if ();
    qvr_stream_if #(.T(qvr_pkg::t_rot)) rot_if ();

    quaternion_vector_rotate_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vec      (vec_if),
        .o_rot      (rot_if)
    );

    // Quaternion as the predictor sees it.
    logic signed [qvr_pkg::QC_W-1:0] cur_qx, cur_qy, cur_qz, cur_qw;
    qvr_pkg::t_rot pending_rot[$];
    t_row stim_table[$];
    int   n_errors = 0;
    int   n_rot_done = 0;
    bit   burst = 1'b0;
    int   idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        vec_if.valid = 1'b0;
        vec_if.data  = '0;
        rot_if.ready = 1'b0;
    end

    // Divide by the squared norm, round half away from zero, clamp to 32 bits.
    function automatic logic [31:0] div_round_clamp(logic signed [127:0] num,
                                                    logic signed [127:0] nrm,
                                                    inout bit sat);
        logic signed [127:0] mag, quo, rem, lim;
        bit neg;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = mag / nrm;
        rem = mag % nrm;
        if (2 * rem >= nrm)
            quo = quo + 1;
        lim = neg ? 128'sh8000_0000 : 128'sh7FFF_FFFF;
        if (quo > lim) begin
            sat = 1'b1;
            quo = lim;
        end
        return neg ? -quo[31:0] : quo[31:0];
    endfunction

    function automatic qvr_pkg::t_rot rotate_vec(qvr_pkg::t_vec v);
        logic signed [127:0] x, y, z, w, vx, vy, vz, nrm, a, d2, w2, c0, c1, c2;
        qvr_pkg::t_rot r;
        bit sat;
        x = cur_qx; y = cur_qy; z = cur_qz; w = cur_qw;
        vx = v.vec_x; vy = v.vec_y; vz = v.vec_z;
        r = '0;
        sat = 1'b0;
        nrm = w * w + x * x + y * y + z * z;
        if (nrm == 0) begin
            r.zero_quat_error = 1'b1;
            return r;
        end
        a  = w * w - x * x - y * y - z * z;
        d2 = 2 * (x * vx + y * vy + z * vz);
        w2 = 2 * w;
        c0 = y * vz - z * vy;
        c1 = z * vx - x * vz;
        c2 = x * vy - y * vx;
        r.rot_x = div_round_clamp(a * vx + d2 * x + w2 * c0, nrm, sat);
        r.rot_y = div_round_clamp(a * vy + d2 * y + w2 * c1, nrm, sat);
        r.rot_z = div_round_clamp(a * vz + d2 * z + w2 * c2, nrm, sat);
        r.saturated = sat;
        return r;
    endfunction

    // Registers are only written once every result has come back.
    task automatic write_quat(logic signed [qvr_pkg::QC_W-1:0] qx, qy, qz, qw);
        logic [qvr_pkg::QC_W-1:0] vals[4];
        vals = '{qx, qy, qz, qw};
        while (pending_rot.size() != 0)
            @(posedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= qvr_pkg::CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_qx = qx; cur_qy = qy; cur_qz = qz; cur_qw = qw;
    endtask

    task automatic send_vec(qvr_pkg::t_vec v, bit typed, qvr_pkg::t_rot rot);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            vec_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vec_if.valid <= 1'b1;
        vec_if.data  <= v;
        @(posedge i_clk);
        while (!vec_if.ready)
            @(posedge i_clk);
        pending_rot.push_back(typed ? rot : rotate_vec(v));
    endtask

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return VMAX;
            1: return VMIN;
            2: return $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic logic signed [qvr_pkg::QC_W-1:0] rand_quat_comp();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return $signed(16'($urandom_range(0, 31))) - 16'sd16;
            default: return $signed(16'($urandom));
        endcase
    endfunction

    function automatic void add_cfg(logic signed [qvr_pkg::QC_W-1:0] qx, qy, qz, qw);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.qx = qx; r.qy = qy; r.qz = qz; r.qw = qw;
        stim_table.push_back(r);
    endfunction

    function automatic void add_vec(logic signed [31:0] x, y, z, bit typed,
                                    logic signed [31:0] ex, ey, ez,
                                    bit err, bit sat);
        t_row r;
        r = '{default: '0};
        r.vec = '{x, y, z};
        r.typed = typed;
        r.rot = '{ex, ey, ez, err, sat};
        stim_table.push_back(r);
    endfunction

    initial begin
        qvr_pkg::t_vec v;
        qvr_pkg::t_rot none;
        none = '0;
        cur_qx = 0; cur_qy = 0; cur_qz = 0; cur_qw = qvr_pkg::QUAT_W_RESET;

        // Identity after reset passes vectors through unchanged.
        add_vec(0, 0, 0, 1, 0, 0, 0, 0, 0);
        add_vec(VMAX, VMIN, -1, 1, VMAX, VMIN, -1, 0, 0);
        add_vec(VMIN, VMAX, 1, 1, VMIN, VMAX, 1, 0, 0);
        add_vec(1, -1, 32'sh1234_5678, 1, 1, -1, 32'sh1234_5678, 0, 0);
        // Zero quaternion.
        add_cfg(0, 0, 0, 0);
        add_vec(VMAX, VMAX, VMAX, 1, 0, 0, 0, 1, 0);
        add_vec(VMIN, 0, 1, 1, 0, 0, 0, 1, 0);
        // Quarter turn about z.
        add_cfg(0, 0, 11585, 11585);
        add_vec(32'sh10000, 0, 0, 0, 0, 0, 0, 0, 0);
        add_vec(VMAX, VMAX, VMIN, 0, 0, 0, 0, 0, 0);
        // Eighth turn about z, long diagonal vector clamps.
        add_cfg(0, 0, 6270, 15137);
        add_vec(VMAX, VMAX, 0, 0, 0, 0, 0, 0, 0);
        add_vec(VMIN, VMIN, VMIN, 0, 0, 0, 0, 0, 0);
        add_cfg(-32768, -32768, -32768, -32768);
        add_vec(VMAX, VMIN, VMAX, 0, 0, 0, 0, 0, 0);
        add_vec(1, 2, 3, 0, 0, 0, 0, 0, 0);
        add_cfg(32767, -32768, 32767, -32768);
        add_vec(VMIN, VMAX, -5, 0, 0, 0, 0, 0, 0);
        add_vec(-7, 9, VMAX, 0, 0, 0, 0, 0, 0);
        // Negative real part alone is still the identity.
        add_cfg(0, 0, 0, -32768);
        add_vec(VMIN, VMAX, 7, 1, VMIN, VMAX, 7, 0, 0);
        // Tiny half turn about x; negating the minimum clamps.
        add_cfg(1, 0, 0, 0);
        add_vec(3, VMIN, VMAX, 0, 0, 0, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[i]) begin
            if (stim_table[i].is_cfg) begin
                vec_if.valid <= 1'b0;
                write_quat(stim_table[i].qx, stim_table[i].qy,
                           stim_table[i].qz, stim_table[i].qw);
            end else begin
                send_vec(stim_table[i].vec, stim_table[i].typed, stim_table[i].rot);
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            vec_if.valid <= 1'b0;
            if (ph == 7)
                write_quat(0, 0, 0, 0);
            else
                write_quat(rand_quat_comp(), rand_quat_comp(),
                           rand_quat_comp(), rand_quat_comp());
            burst = (ph % 3 == 1);
            repeat (160) begin
                v = '{rand_comp(), rand_comp(), rand_comp()};
                send_vec(v, 1'b0, none);
            end
        end
        vec_if.valid <= 1'b0;

        while (pending_rot.size() != 0)
            @(posedge i_clk);
        repeat (qvr_pkg::LAT + 10) @(posedge i_clk);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls, one long hold-off so the pipeline backs up.
    initial begin
        int stall;
        bit held;
        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (!held && n_rot_done >= 600) begin
                held = 1'b1;
                stall = LONG_HOLD;
            end else begin
                stall = burst ? 0 : $urandom_range(0, 9);
            end
            if (stall != 0) begin
                rot_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rot_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rot_if.valid)
                @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        qvr_pkg::t_rot exp_rot;
        if (i_rst_n && rot_if.valid && rot_if.ready) begin
            n_rot_done++;
            if (pending_rot.size() == 0) begin
                $error("unexpected result transaction");
                n_errors++;
            end else begin
                exp_rot = pending_rot.pop_front();
                if (rot_if.data.rot_x !== exp_rot.rot_x) begin
                    $error("rot_x expected %0d got %0d", exp_rot.rot_x, rot_if.data.rot_x);
                    n_errors++;
                end
                if (rot_if.data.rot_y !== exp_rot.rot_y) begin
                    $error("rot_y expected %0d got %0d", exp_rot.rot_y, rot_if.data.rot_y);
                    n_errors++;
                end
                if (rot_if.data.rot_z !== exp_rot.rot_z) begin
                    $error("rot_z expected %0d got %0d", exp_rot.rot_z, rot_if.data.rot_z);
                    n_errors++;
                end
                if (rot_if.data.zero_quat_error !== exp_rot.zero_quat_error) begin
                    $error("zero_quat_error expected %0b got %0b",
                           exp_rot.zero_quat_error, rot_if.data.zero_quat_error);
                    n_errors++;
                end
                if (rot_if.data.saturated !== exp_rot.saturated) begin
                    $error("saturated expected %0b got %0b",
                           exp_rot.saturated, rot_if.data.saturated);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction or register write.
    always @(posedge i_clk) begin
        if ((vec_if.valid && vec_if.ready) || (rot_if.valid && rot_if.ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

/* filelist.f */
hw/rtl/qvr_pkg.sv
hw/rtl/qvr_stream_if.sv
hw/rtl/qvr_div.sv
hw/rtl/quaternion_vector_rotate_top.sv
test/tb.sv
